// File: sv/fbmt_pkg.sv
// ============================================================================
// fbmt_pkg
// Shared types and codes for the block-mapped flash translation unit.
// ============================================================================
package fbmt_pkg;

    // Host request beat.
    typedef struct packed {
        logic       opcode;
        logic [5:0] sector_number;
    } req_t;

    // Flash command beat.
    typedef struct packed {
        logic [2:0] action;
        logic [6:0] page_address;
        logic [6:0] source_page;
        logic [4:0] erase_block;
        logic       last;
    } res_t;

    // Classified request passed from the front end to the back end.
    typedef struct packed {
        logic       op;
        logic [5:0] lsn;
        logic [5:0] lbn;
        logic       lbn_ok;
    } job_t;

    typedef enum logic [2:0] {
        ACT_PROGRAM  = 3'd0,
        ACT_COPY     = 3'd1,
        ACT_ERASE    = 3'd2,
        ACT_READ     = 3'd3,
        ACT_NOTFOUND = 3'd4,
        ACT_NOFREE   = 3'd5
    } action_t;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

endpackage

// File: sv/flash_block_map_translator_unit.sv
// ============================================================================
// flash_block_map_translator_unit
// Block-mapped flash translation: host sector requests in, flash commands out.
// ============================================================================
//
//   Channel   Handshake      Beat type        Direction
//   request   push / full    fbmt_pkg::req_t  host to unit
//   command   pop / empty    fbmt_pkg::res_t  unit to flash sequencer
//
// A read walks the pages of its mapped block. A write may also run the
// one-block-a-cycle free and stale scans, a page walk and a relocation; the
// sector tag memory has one write port and one registered read port. Reset
// clears the map and page flags and marks every block erased at once. A full
// command queue stalls only the sequencer; requests still queue.
//
module flash_block_map_translator_unit #(
    parameter int LOGICAL_BLOCKS    = 16,
    parameter int PHYSICAL_BLOCKS   = 32,
    parameter int PAGES_PER_BLOCK_N = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  fbmt_pkg::req_t request,
    input  logic           pop,
    output logic           empty,
    output fbmt_pkg::res_t command
);
    import fbmt_pkg::*;

    job_t job_in;
    job_t job_out;
    logic job_push;
    logic job_full;
    logic job_pop;
    logic job_empty;
    res_t res;
    logic res_push;
    logic res_full;

    // Front end: accept and classify.
    fbmt_front #(
        .LOGICAL_BLOCKS    (LOGICAL_BLOCKS),
        .PAGES_PER_BLOCK_N (PAGES_PER_BLOCK_N)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .request  (request),
        .full     (full),
        .job_push (job_push),
        .job      (job_in),
        .job_full (job_full)
    );

    // Queue between front and back.
    fbmt_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (2)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job_in),
        .full  (job_full),
        .pop   (job_pop),
        .rdata (job_out),
        .empty (job_empty)
    );

    // Back end: map upkeep and command generation.
    fbmt_back #(
        .LOGICAL_BLOCKS    (LOGICAL_BLOCKS),
        .PHYSICAL_BLOCKS   (PHYSICAL_BLOCKS),
        .PAGES_PER_BLOCK_N (PAGES_PER_BLOCK_N)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .job       (job_out),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    // Command output queue.
    fbmt_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (command),
        .empty (empty)
    );

endmodule

// File: sv/fbmt_fifo.sv
// ============================================================================
// fbmt_fifo
// Small synchronous queue with push/full and pop/empty sides.
// ============================================================================
module fbmt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: sv/fbmt_front.sv
// ============================================================================
// fbmt_front
// Accepts host requests and classifies them by logical block.
// ============================================================================
module fbmt_front #(
    parameter int LOGICAL_BLOCKS    = 16,
    parameter int PAGES_PER_BLOCK_N = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fbmt_pkg::req_t request,
    output logic          full,
    output logic          job_push,
    output fbmt_pkg::job_t job,
    input  logic          job_full
);
    import fbmt_pkg::*;

    // Sector to logical block lookup, built at elaboration.
    function automatic logic [63:0][5:0] lbn_table();
        logic [63:0][5:0] t;
        int               q;
        int               r;
        q = 0;
        r = 0;
        for (int s = 0; s < 64; s++)
        begin
            t[s] = 6'(q);
            r++;
            if (r == PAGES_PER_BLOCK_N)
            begin
                r = 0;
                q++;
            end
        end
        return t;
    endfunction

    localparam logic [63:0][5:0] LBN_TAB = lbn_table();

    logic valid_reg;
    logic valid_next;
    job_t job_reg;
    job_t job_next;
    logic accept;

    assign full     = valid_reg && job_full;
    assign accept   = push && !full;
    assign job_push = valid_reg && !job_full;
    assign job      = job_reg;

    // Classify the incoming beat.
    always_comb
    begin
        job_next.op     = request.opcode;
        job_next.lsn    = request.sector_number;
        job_next.lbn    = LBN_TAB[request.sector_number];
        job_next.lbn_ok = int'(LBN_TAB[request.sector_number]) < LOGICAL_BLOCKS;
        valid_next      = accept || (valid_reg && job_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

endmodule

// File: sv/fbmt_back.sv
// ============================================================================
// fbmt_back
// Sequencer that keeps the block map and page metadata and issues commands.
// ============================================================================
module fbmt_back #(
    parameter int LOGICAL_BLOCKS    = 16,
    parameter int PHYSICAL_BLOCKS   = 32,
    parameter int PAGES_PER_BLOCK_N = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_empty,
    output logic           job_pop,
    input  fbmt_pkg::job_t job,
    input  logic           res_full,
    output logic           res_push,
    output fbmt_pkg::res_t res
);
    import fbmt_pkg::*;

    localparam int NPAGES    = PHYSICAL_BLOCKS * PAGES_PER_BLOCK_N;
    localparam int PGW       = $clog2(NPAGES);
    localparam int BW        = $clog2(PHYSICAL_BLOCKS);
    localparam int PW        = $clog2(PAGES_PER_BLOCK_N);
    localparam int NW        = $clog2(PAGES_PER_BLOCK_N + 1);
    localparam int LBN_SPAN  = 63 / PAGES_PER_BLOCK_N + 1;
    localparam int MAP_DEPTH = (LOGICAL_BLOCKS < LBN_SPAN) ? LOGICAL_BLOCKS : LBN_SPAN;
    localparam int LBW       = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

    typedef enum logic [13:0] {
        ST_IDLE        = 14'b00000000000001,
        ST_DISPATCH    = 14'b00000000000010,
        ST_SCAN_FREE   = 14'b00000000000100,
        ST_MARK_RD     = 14'b00000000001000,
        ST_MARK_CMP    = 14'b00000000010000,
        ST_COPY_RD     = 14'b00000000100000,
        ST_COPY_WR     = 14'b00000001000000,
        ST_ERASE_OLD   = 14'b00000010000000,
        ST_SCAN_STALE  = 14'b00000100000000,
        ST_ERASE_STALE = 14'b00001000000000,
        ST_PROGRAM     = 14'b00010000000000,
        ST_READ_RD     = 14'b00100000000000,
        ST_READ_CMP    = 14'b01000000000000,
        ST_REPLY       = 14'b10000000000000
    } state_t;

    function automatic logic [PGW-1:0] page_of(input logic [BW-1:0] b, input logic [NW-1:0] p);
        return PGW'(PGW'(b) * PGW'(PAGES_PER_BLOCK_N) + PGW'(p));
    endfunction

    // Control registers.
    state_t         state_reg,  state_next;
    job_t           job_reg,    job_next;
    logic [PW-1:0]  pg_reg,     pg_next;
    logic [BW-1:0]  blk_reg,    blk_next;
    logic [1:0]     nfree_reg,  nfree_next;
    logic [BW-1:0]  free_reg,   free_next;
    logic [BW-1:0]  old_reg,    old_next;
    logic [NW-1:0]  cnt_reg,    cnt_next;
    logic [PGW-1:0] hit_reg,    hit_next;
    logic           found_reg,  found_next;
    logic [2:0]     reply_reg,  reply_next;

    // Map and page metadata.
    logic                 map_present_reg [MAP_DEPTH];
    logic [BW-1:0]        map_block_reg   [MAP_DEPTH];
    logic [NW-1:0]        map_next_reg    [MAP_DEPTH];
    logic [NPAGES-1:0]    tagged_reg;
    logic [NPAGES-1:0]    stale_reg;
    logic [PHYSICAL_BLOCKS-1:0] erased_reg;
    logic [5:0]           tag_mem [NPAGES];
    logic [5:0]           tag_rd_reg;

    // Derived lookups.
    logic [LBW-1:0] lbn_ix;
    logic           cur_present;
    logic [BW-1:0]  cur_blk;
    logic [NW-1:0]  cur_next;
    logic           cur_full;
    logic [PGW-1:0] addr_cur;
    logic [PGW-1:0] addr_src;
    logic [PGW-1:0] addr_dst;
    logic [PGW-1:0] addr_prog;
    logic [PGW-1:0] rd_addr;
    logic           src_valid;
    logic           tag_hit;
    logic           read_hit;
    logic           stale_all;
    logic           pg_last;
    logic           blk_last;
    logic           blk_erased_now;
    logic [1:0]     nfree_scan;
    logic [BW-1:0]  free_scan;
    logic           tag_we;
    logic [PGW-1:0] tag_wa;
    logic [5:0]     tag_wd;
    logic [31:0]    pa_wide;
    logic [31:0]    sp_wide;
    logic [31:0]    eb_wide;

    assign lbn_ix      = LBW'(job_reg.lbn);
    assign cur_present = map_present_reg[lbn_ix];
    assign cur_blk     = map_block_reg[lbn_ix];
    assign cur_next    = map_next_reg[lbn_ix];
    assign cur_full    = cur_next >= NW'(PAGES_PER_BLOCK_N);
    assign addr_cur    = page_of(cur_blk, NW'(pg_reg));
    assign addr_src    = page_of(old_reg, NW'(pg_reg));
    assign addr_dst    = page_of(free_reg, cnt_reg);
    assign addr_prog   = page_of(cur_blk, cur_next);
    assign src_valid   = tagged_reg[addr_src] && !stale_reg[addr_src];
    assign tag_hit     = tagged_reg[addr_cur] && (tag_rd_reg == job_reg.lsn);
    assign read_hit    = tag_hit && !stale_reg[addr_cur];
    assign stale_all   = &stale_reg[page_of(blk_reg, NW'(0)) +: PAGES_PER_BLOCK_N];
    assign pg_last     = (pg_reg == PW'(PAGES_PER_BLOCK_N - 1));
    assign blk_last    = (blk_reg == BW'(PHYSICAL_BLOCKS - 1));

    // Free block scan step: first erased block and a saturating count.
    assign blk_erased_now = erased_reg[blk_reg];
    assign nfree_scan = (blk_erased_now && nfree_reg != 2'd2) ? nfree_reg + 2'd1 : nfree_reg;
    assign free_scan  = (blk_erased_now && nfree_reg == 2'd0) ? blk_reg : free_reg;

    // Sector tag store: one write and one registered read a cycle.
    assign rd_addr = (state_reg == ST_COPY_RD || state_reg == ST_COPY_WR) ? addr_src : addr_cur;
    assign tag_we  = ((state_reg == ST_COPY_WR) || (state_reg == ST_PROGRAM)) && !res_full;
    assign tag_wa  = (state_reg == ST_COPY_WR) ? addr_dst : addr_prog;
    assign tag_wd  = (state_reg == ST_COPY_WR) ? tag_rd_reg : job_reg.lsn;

    always_ff @(posedge clk)
    begin
        tag_rd_reg <= tag_mem[rd_addr];
        if (tag_we)
        begin
            tag_mem[tag_wa] <= tag_wd;
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        pg_next    = pg_reg;
        blk_next   = blk_reg;
        nfree_next = nfree_reg;
        free_next  = free_reg;
        old_next   = old_reg;
        cnt_next   = cnt_reg;
        hit_next   = hit_reg;
        found_next = found_reg;
        reply_next = reply_reg;
        job_pop    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop    = 1'b1;
                    job_next   = job;
                    pg_next    = '0;
                    blk_next   = '0;
                    nfree_next = '0;
                    cnt_next   = '0;
                    hit_next   = '0;
                    found_next = 1'b0;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (job_reg.op == OP_READ)
                begin
                    if (!job_reg.lbn_ok || !cur_present)
                    begin
                        reply_next = ACT_NOTFOUND;
                        state_next = ST_REPLY;
                    end
                    else
                    begin
                        state_next = ST_READ_RD;
                    end
                end
                else if (!job_reg.lbn_ok)
                begin
                    reply_next = ACT_NOFREE;
                    state_next = ST_REPLY;
                end
                else if (!cur_present || cur_full)
                begin
                    state_next = ST_SCAN_FREE;
                end
                else
                begin
                    state_next = ST_MARK_RD;
                end
            end
            ST_SCAN_FREE:
            begin
                nfree_next = nfree_scan;
                free_next  = free_scan;
                if (blk_last)
                begin
                    blk_next = '0;
                    if (nfree_scan == 2'd0)
                    begin
                        reply_next = ACT_NOFREE;
                        state_next = ST_REPLY;
                    end
                    else
                    begin
                        state_next = ST_MARK_RD;
                    end
                end
                else
                begin
                    blk_next = blk_reg + 1'b1;
                end
            end
            ST_MARK_RD:
            begin
                state_next = ST_MARK_CMP;
            end
            ST_MARK_CMP:
            begin
                if (pg_last)
                begin
                    pg_next = '0;
                    if (cur_full)
                    begin
                        cnt_next   = '0;
                        old_next   = cur_blk;
                        state_next = ST_COPY_RD;
                    end
                    else
                    begin
                        state_next = ST_PROGRAM;
                    end
                end
                else
                begin
                    pg_next    = pg_reg + 1'b1;
                    state_next = ST_MARK_RD;
                end
            end
            ST_COPY_RD:
            begin
                if (src_valid)
                begin
                    state_next = ST_COPY_WR;
                end
                else if (pg_last)
                begin
                    pg_next    = '0;
                    state_next = ST_ERASE_OLD;
                end
                else
                begin
                    pg_next = pg_reg + 1'b1;
                end
            end
            ST_COPY_WR:
            begin
                if (!res_full)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (pg_last)
                    begin
                        pg_next    = '0;
                        state_next = ST_ERASE_OLD;
                    end
                    else
                    begin
                        pg_next    = pg_reg + 1'b1;
                        state_next = ST_COPY_RD;
                    end
                end
            end
            ST_ERASE_OLD:
            begin
                if (!res_full)
                begin
                    blk_next   = '0;
                    state_next = (nfree_reg <= 2'd1) ? ST_SCAN_STALE : ST_PROGRAM;
                end
            end
            ST_SCAN_STALE:
            begin
                if (stale_all)
                begin
                    state_next = ST_ERASE_STALE;
                end
                else if (blk_last)
                begin
                    state_next = ST_PROGRAM;
                end
                else
                begin
                    blk_next = blk_reg + 1'b1;
                end
            end
            ST_ERASE_STALE:
            begin
                if (!res_full)
                begin
                    state_next = ST_PROGRAM;
                end
            end
            ST_PROGRAM:
            begin
                if (!res_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ_RD:
            begin
                state_next = ST_READ_CMP;
            end
            ST_READ_CMP:
            begin
                if (read_hit)
                begin
                    hit_next   = addr_cur;
                    found_next = 1'b1;
                end
                if (pg_last)
                begin
                    pg_next    = '0;
                    reply_next = (found_reg || read_hit) ? ACT_READ : ACT_NOTFOUND;
                    state_next = ST_REPLY;
                end
                else
                begin
                    pg_next    = pg_reg + 1'b1;
                    state_next = ST_READ_RD;
                end
            end
            ST_REPLY:
            begin
                if (!res_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        pg_reg    <= pg_next;
        blk_reg   <= blk_next;
        nfree_reg <= nfree_next;
        free_reg  <= free_next;
        old_reg   <= old_next;
        cnt_reg   <= cnt_next;
        hit_reg   <= hit_next;
        found_reg <= found_next;
        reply_reg <= reply_next;
    end

    // Map, page flags and erased flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAP_DEPTH; i++)
            begin
                map_present_reg[i] <= 1'b0;
                map_block_reg[i]   <= '0;
                map_next_reg[i]    <= '0;
            end
            tagged_reg <= '0;
            stale_reg  <= '0;
            erased_reg <= '1;
        end
        else
        begin
            unique case (state_reg)
                ST_SCAN_FREE:
                begin
                    if (blk_last && nfree_scan != 2'd0 && !cur_present)
                    begin
                        map_present_reg[lbn_ix] <= 1'b1;
                        map_block_reg[lbn_ix]   <= free_scan;
                        map_next_reg[lbn_ix]    <= '0;
                    end
                end
                ST_MARK_CMP:
                begin
                    if (tag_hit)
                    begin
                        stale_reg[addr_cur] <= 1'b1;
                    end
                    if (pg_last && cur_full)
                    begin
                        map_block_reg[lbn_ix] <= free_reg;
                    end
                end
                ST_COPY_WR:
                begin
                    if (!res_full)
                    begin
                        tagged_reg[addr_dst] <= 1'b1;
                        stale_reg[addr_dst]  <= 1'b0;
                        stale_reg[addr_src]  <= 1'b1;
                        erased_reg[free_reg] <= 1'b0;
                    end
                end
                ST_ERASE_OLD:
                begin
                    if (!res_full)
                    begin
                        tagged_reg[page_of(old_reg, NW'(0)) +: PAGES_PER_BLOCK_N] <= '0;
                        stale_reg[page_of(old_reg, NW'(0)) +: PAGES_PER_BLOCK_N]  <= '0;
                        erased_reg[old_reg]  <= 1'b1;
                        map_next_reg[lbn_ix] <= cnt_reg;
                    end
                end
                ST_ERASE_STALE:
                begin
                    if (!res_full)
                    begin
                        tagged_reg[page_of(blk_reg, NW'(0)) +: PAGES_PER_BLOCK_N] <= '0;
                        stale_reg[page_of(blk_reg, NW'(0)) +: PAGES_PER_BLOCK_N]  <= '0;
                        erased_reg[blk_reg] <= 1'b1;
                    end
                end
                ST_PROGRAM:
                begin
                    if (!res_full)
                    begin
                        tagged_reg[addr_prog] <= 1'b1;
                        stale_reg[addr_prog]  <= 1'b0;
                        erased_reg[cur_blk]   <= 1'b0;
                        map_next_reg[lbn_ix]  <= cur_next + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Command beat assembly.
    always_comb
    begin
        res      = '0;
        res_push = 1'b0;
        pa_wide  = '0;
        sp_wide  = '0;
        eb_wide  = '0;
        unique case (state_reg)
            ST_COPY_WR:
            begin
                res_push   = !res_full;
                res.action = ACT_COPY;
                pa_wide    = 32'(addr_dst);
                sp_wide    = 32'(addr_src);
            end
            ST_ERASE_OLD:
            begin
                res_push   = !res_full;
                res.action = ACT_ERASE;
                eb_wide    = 32'(old_reg);
            end
            ST_ERASE_STALE:
            begin
                res_push   = !res_full;
                res.action = ACT_ERASE;
                eb_wide    = 32'(blk_reg);
            end
            ST_PROGRAM:
            begin
                res_push   = !res_full;
                res.action = ACT_PROGRAM;
                res.last   = 1'b1;
                pa_wide    = 32'(addr_prog);
            end
            ST_REPLY:
            begin
                res_push   = !res_full;
                res.action = reply_reg;
                res.last   = 1'b1;
                pa_wide    = (reply_reg == ACT_READ) ? 32'(hit_reg) : '0;
            end
            default:
            begin
            end
        endcase
        res.page_address = pa_wide[6:0];
        res.source_page  = sp_wide[6:0];
        res.erase_block  = eb_wide[4:0];
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the block-mapped flash translation unit: directed
// and random host sector requests go in, and every flash command beat is compared with
// a model of the map, page tags and erased flags kept in the bench.
// ============================================================================
module tb;
    import fbmt_pkg::*;

    localparam int LBLK  = 16;
    localparam int PBLK  = 32;
    localparam int PPB   = 4;
    localparam int NPAGE = PBLK * PPB;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 2 * PBLK + 4 * PPB + 8;

    // Scoreboard: owns the flash map model and the queue of pending commands.
    class ftl_scoreboard;
        bit         lmap_valid [LBLK];
        bit   [4:0] lmap_blk   [LBLK];
        int         lmap_fill  [LBLK];
        bit         pg_used    [NPAGE];
        bit   [5:0] pg_sector  [NPAGE];
        bit         pg_stale   [NPAGE];
        bit         blk_free   [PBLK];
        res_t       pending_cmds[$];
        int         errors;

        function new();
            for (int i = 0; i < LBLK; i++)
            begin
                lmap_valid[i] = 0;
                lmap_blk[i] = 0;
                lmap_fill[i] = 0;
            end
            for (int i = 0; i < NPAGE; i++)
            begin
                pg_used[i] = 0;
                pg_sector[i] = 0;
                pg_stale[i] = 0;
            end
            for (int i = 0; i < PBLK; i++)
                blk_free[i] = 1;
            errors = 0;
        endfunction

        function void add_cmd(action_t act, int pa, int sp, int eb);
            res_t c;
            c.action = act;
            c.page_address = pa[6:0];
            c.source_page = sp[6:0];
            c.erase_block = eb[4:0];
            c.last = 0;
            pending_cmds.push_back(c);
        endfunction

        function void erase_phys(int b);
            for (int p = 0; p < PPB; p++)
            begin
                pg_used[b * PPB + p] = 0;
                pg_stale[b * PPB + p] = 0;
            end
            blk_free[b] = 1;
        endfunction

        // Host write: a no-free reply, or stale marking, optional relocation, then program.
        function void apply_write(int lsn);
            int lbn, nfree, freeb, old, src, dst, cnt;
            lbn = lsn / PPB;
            nfree = 0;
            freeb = 0;
            if (lbn >= LBLK)
            begin
                add_cmd(ACT_NOFREE, 0, 0, 0);
                return;
            end
            for (int b = 0; b < PBLK; b++)
                if (blk_free[b])
                begin
                    if (nfree == 0)
                        freeb = b;
                    nfree++;
                end
            if ((!lmap_valid[lbn] || lmap_fill[lbn] >= PPB) && nfree == 0)
            begin
                add_cmd(ACT_NOFREE, 0, 0, 0);
                return;
            end
            if (!lmap_valid[lbn])
            begin
                lmap_valid[lbn] = 1;
                lmap_blk[lbn] = 5'(freeb);
                lmap_fill[lbn] = 0;
            end
            for (int p = 0; p < PPB; p++)
                if (pg_used[lmap_blk[lbn] * PPB + p] &&
                    pg_sector[lmap_blk[lbn] * PPB + p] == lsn)
                    pg_stale[lmap_blk[lbn] * PPB + p] = 1;
            if (lmap_fill[lbn] >= PPB)
            begin
                old = lmap_blk[lbn];
                lmap_blk[lbn] = 5'(freeb);
                lmap_fill[lbn] = 0;
                for (int p = 0; p < PPB; p++)
                begin
                    src = old * PPB + p;
                    if (pg_used[src] && !pg_stale[src])
                    begin
                        dst = freeb * PPB + lmap_fill[lbn];
                        pg_used[dst] = 1;
                        pg_sector[dst] = pg_sector[src];
                        pg_stale[dst] = 0;
                        blk_free[freeb] = 0;
                        lmap_fill[lbn]++;
                        pg_stale[src] = 1;
                        add_cmd(ACT_COPY, dst, src, 0);
                    end
                end
                erase_phys(old);
                add_cmd(ACT_ERASE, 0, 0, old);
                // The last free block was used: reclaim the first fully stale one.
                if (nfree <= 1)
                begin
                    for (int b = 0; b < PBLK; b++)
                    begin
                        cnt = 0;
                        for (int p = 0; p < PPB; p++)
                            if (pg_stale[b * PPB + p])
                                cnt++;
                        if (cnt == PPB)
                        begin
                            erase_phys(b);
                            add_cmd(ACT_ERASE, 0, 0, b);
                            break;
                        end
                    end
                end
            end
            dst = lmap_blk[lbn] * PPB + lmap_fill[lbn];
            pg_used[dst] = 1;
            pg_sector[dst] = 6'(lsn);
            pg_stale[dst] = 0;
            blk_free[lmap_blk[lbn]] = 0;
            lmap_fill[lbn]++;
            add_cmd(ACT_PROGRAM, dst, 0, 0);
        endfunction

        // Host read: the highest valid page holding the sector wins.
        function void apply_read(int lsn);
            int lbn, hit, base;
            bit found;
            lbn = lsn / PPB;
            found = 0;
            hit = 0;
            if (lbn < LBLK && lmap_valid[lbn])
            begin
                base = lmap_blk[lbn] * PPB;
                for (int p = 0; p < PPB; p++)
                    if (pg_used[base + p] && !pg_stale[base + p] &&
                        pg_sector[base + p] == lsn)
                    begin
                        hit = base + p;
                        found = 1;
                    end
            end
            if (found)
                add_cmd(ACT_READ, hit, 0, 0);
            else
                add_cmd(ACT_NOTFOUND, 0, 0, 0);
        endfunction

        function void note_request(req_t r);
            if (r.opcode == OP_WRITE)
                apply_write(int'(r.sector_number));
            else
                apply_read(int'(r.sector_number));
            pending_cmds[pending_cmds.size() - 1].last = 1;
        endfunction

        function void check_command(res_t got);
            res_t want;
            if (pending_cmds.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected command beat %h", got);
                return;
            end
            want = pending_cmds.pop_front();
            if (got.action !== want.action || got.page_address !== want.page_address ||
                got.source_page !== want.source_page ||
                got.erase_block !== want.erase_block || got.last !== want.last)
            begin
                errors++;
                if (errors <= 10)
                    $display({"command mismatch: expected act=%0d pa=%0d sp=%0d eb=%0d ",
                              "last=%0d, got act=%0d pa=%0d sp=%0d eb=%0d last=%0d"},
                             want.action, want.page_address, want.source_page,
                             want.erase_block, want.last, got.action, got.page_address,
                             got.source_page, got.erase_block, got.last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    req_t request;
    logic pop;
    logic empty;
    res_t command;

    ftl_scoreboard sb;
    int  cycle_count = 0;
    bit  quiet_phase;

    flash_block_map_translator_unit dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .request(request),
        .pop(pop), .empty(empty), .command(command)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Cycle watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Command side: sample accepted beats, then choose pop for the next cycle.
    int pop_gap;
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 0;
            pop_gap <= 0;
        end
        else
        begin
            if (pop && !empty)
                sb.check_command(command);
            if (pop_gap > 0)
            begin
                pop_gap <= pop_gap - 1;
                pop <= 0;
            end
            else if (!quiet_phase && $urandom_range(0, 7) == 0)
            begin
                pop_gap <= $urandom_range(0, 11);
                pop <= 0;
            end
            else
                pop <= 1;
        end
    end

    // One request beat, held until accepted.
    task automatic send_request(bit op, bit [5:0] lsn);
        req_t r;
        r.opcode = op;
        r.sector_number = lsn;
        push <= 1;
        request <= r;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_request(r);
    endtask

    task automatic send_idle();
        int n;
        if (!quiet_phase && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 12);
            push <= 0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        push <= 0;
        @(posedge clk);
        while (sb.pending_cmds.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        bit op;
        bit [5:0] lsn;
        sb = new();
        quiet_phase = 0;
        rst_n = 0;
        push = 0;
        request = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: unmapped reads, sector extremes, fill one block to relocate.
        send_request(OP_READ, 6'd0);
        send_request(OP_READ, 6'd63);
        send_request(OP_WRITE, 6'd0);
        send_request(OP_READ, 6'd0);
        send_request(OP_READ, 6'd1);
        send_request(OP_WRITE, 6'd63);
        send_request(OP_READ, 6'd63);
        for (int i = 0; i < 6; i++)
            send_request(OP_WRITE, 6'd1);
        send_request(OP_READ, 6'd1);
        send_request(OP_WRITE, 6'd2);
        send_request(OP_WRITE, 6'd3);
        send_request(OP_WRITE, 6'd0);
        send_request(OP_READ, 6'd0);
        send_request(OP_READ, 6'd42);
        wait_drained();

        // Random traffic with a bias toward a few hot blocks to force relocation.
        for (int i = 0; i < 150; i++)
        begin
            if (i == 120)
                quiet_phase = 1;
            if (i == 70)
                wait_drained();
            op = ($urandom_range(0, 2) == 0) ? OP_READ : OP_WRITE;
            if ($urandom_range(0, 3) != 0)
                lsn = 6'($urandom_range(0, 11));
            else
                lsn = 6'($urandom_range(0, 63));
            send_request(op, lsn);
            send_idle();
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending_cmds.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
